>>> rtl/core/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define RDSM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// clocked implication, disabled while reset is asserted
`define RDSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");

`endif

>>> rtl/core/rdsm_pkg.sv
// package: types, constants and helpers of the dot-star matcher
package rdsm_pkg;

	localparam int PatternMax = 32;
	localparam int AddrW      = $clog2(PatternMax);
	localparam int LenW       = $clog2(PatternMax + 1);
	localparam int RowW       = PatternMax + 1;

	localparam logic [7:0] SymAny  = 8'h2E;
	localparam logic [7:0] SymStar = 8'h2A;

	typedef logic [7:0]       sym_t;
	typedef logic [AddrW-1:0] addr_t;
	typedef logic [LenW-1:0]  len_t;
	typedef logic [RowW-1:0]  row_t;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_TEXT   = 2'd2,
		MODE_END    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FINISH
	} state_t;

	// pattern store access
	typedef struct packed {
		logic  we;
		addr_t waddr;
		sym_t  wdata;
		logic  re;
		addr_t raddr;
	} pmem_req_t;

	localparam row_t RowInit = row_t'(1);

	function automatic logic elem_hits(sym_t pc, sym_t c);
		return (pc == SymAny) || (pc == c);
	endfunction

endpackage

>>> rtl/core/rdsm_chan_if.sv
// handshake channels: command words in, result words out
interface rdsm_cmd_if;
	import rdsm_pkg::*;
	logic  valid;
	logic  ready;
	mode_t mode;
	sym_t  symbol;
	modport source (output valid, output mode, output symbol, input ready);
	modport sink   (input valid, input mode, input symbol, output ready);
endinterface

interface rdsm_res_if;
	logic valid;
	logic ready;
	logic matched;
	logic overflow;
	modport source (output valid, output matched, output overflow, input ready);
	modport sink   (input valid, input matched, input overflow, output ready);
endinterface

>>> rtl/core/rdsm_pattern_mem.sv
// pattern byte store with one write port and one registered read port
module rdsm_pattern_mem (
	input  logic               clk,
	input  rdsm_pkg::pmem_req_t req,
	output rdsm_pkg::sym_t      rdata
);
	import rdsm_pkg::*;

	sym_t mem_q [PatternMax];
	sym_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/regex_dot_star_match.sv
// top level: whole-string matcher for literal, '.' and 'x*' patterns
// Usage: load a pattern with a clear word (mode 0) and append words (mode 1),
// then stream text bytes (mode 2) and close the text with an end word
// (mode 3), which returns one result word with matched and overflow. A text
// byte or end word is accepted while the first pattern read starts, then
// passes pattern position by position through the single cell update unit,
// and a finish step commits the row for a text byte or writes the result
// for an end word; the sweep is serial because a star position needs the new
// bit two positions back. The command channel is not ready while a sweep runs.
// A result waits in an output register, and a new command is taken while it
// waits; only a second end word stalls until the first result is taken.
// Appending past 32 bytes sets a sticky overflow that forces matched to 0
// until the next clear.
module regex_dot_star_match (
	input  logic clk,
	input  logic arst_n,
	rdsm_cmd_if.sink   cmd,
	rdsm_res_if.source res
);
	import rdsm_pkg::*;
`include "assert_macros.svh"

	state_t state_q, state_d;

	// pattern and row state
	len_t  len_q;
	logic  ovf_q;
	row_t  row_q;
	row_t  next_q;
	logic  started_q;

	// current word under work
	mode_t mode_q;
	sym_t  sym_q;
	len_t  j_q;
	sym_t  prev_q;

	// result register
	logic  res_valid_q;
	logic  matched_q;
	logic  overflow_q;

	pmem_req_t mem_req;
	sym_t      pc;

	// control decode
	logic cmd_fire;
	logic step_en;
	logic finish_go;

	rdsm_pattern_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (pc)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid && (cmd.mode inside {MODE_TEXT, MODE_END})) begin
					state_d = (len_q == '0) ? ST_FINISH : ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (j_q == len_q) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (mode_q == MODE_TEXT || !res_valid_q || res.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		cmd.ready = 1'b0;
		step_en   = 1'b0;
		finish_go = 1'b0;
		mem_req   = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				// write an appended byte, or start the first pattern read
				mem_req.we    = cmd.valid && cmd.mode == MODE_APPEND &&
					len_q < LenW'(PatternMax);
				mem_req.waddr = len_q[AddrW-1:0];
				mem_req.wdata = cmd.symbol;
				mem_req.re    = cmd.valid && (cmd.mode inside {MODE_TEXT, MODE_END});
				mem_req.raddr = '0;
			end
			ST_SWEEP: begin
				step_en       = 1'b1;
				// prefetch the byte for the next position
				mem_req.re    = 1'b1;
				mem_req.raddr = j_q[AddrW-1:0];
			end
			ST_FINISH: begin
				finish_go = (mode_q == MODE_TEXT) || !res_valid_q || res.ready;
			end
			default: ;
		endcase
	end

	assign cmd_fire = cmd.valid && cmd.ready;

	// cell update for position j_q
	logic is_star;
	logic j_ge2;
	len_t jm1, jm2;
	logic closed_j;
	logic next_bit;

	always_comb begin
		is_star  = (pc == SymStar);
		j_ge2    = (j_q >= LenW'(2));
		jm1      = j_q - LenW'(1);
		jm2      = j_ge2 ? (j_q - LenW'(2)) : '0;
		// empty-text widening before the first byte of a text
		closed_j = row_q[j_q] | (!started_q && is_star && j_ge2 && row_q[jm2]);
		if (is_star) begin
			next_bit = j_ge2 && (next_q[jm2] || (closed_j && elem_hits(prev_q, sym_q)));
		end else begin
			next_bit = row_q[jm1] && elem_hits(pc, sym_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			row_q       <= RowInit;
			started_q   <= 1'b0;
			res_valid_q <= 1'b0;
			mode_q      <= MODE_CLEAR;
			j_q         <= '0;
		end else begin
			state_q <= state_d;
			// a new result wins over the hand-off of the old one
			if (finish_go && mode_q == MODE_END) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (cmd_fire) begin
				mode_q <= cmd.mode;
				j_q    <= LenW'(1);
				case (cmd.mode)
					MODE_CLEAR: begin
						len_q     <= '0;
						ovf_q     <= 1'b0;
						row_q     <= RowInit;
						started_q <= 1'b0;
					end
					MODE_APPEND: begin
						if (len_q < LenW'(PatternMax)) begin
							len_q <= len_q + LenW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						row_q     <= RowInit;
						started_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (step_en) begin
				row_q[j_q] <= closed_j;
				j_q        <= j_q + LenW'(1);
			end
			if (finish_go) begin
				if (mode_q == MODE_TEXT) begin
					row_q     <= next_q;
					started_q <= 1'b1;
				end else begin
					row_q     <= RowInit;
					started_q <= 1'b0;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			sym_q  <= cmd.symbol;
			next_q <= '0;
		end
		if (step_en) begin
			next_q[j_q] <= next_bit;
			prev_q      <= pc;
		end
		if (finish_go && mode_q == MODE_END) begin
			matched_q  <= !ovf_q && row_q[len_q];
			overflow_q <= ovf_q;
		end
	end

	assign res.valid    = res_valid_q;
	assign res.matched  = matched_q;
	assign res.overflow = overflow_q;

	`RDSM_ASSERT(a_len_bound, clk, arst_n, len_q <= LenW'(PatternMax))
	`RDSM_ASSERT_IMP(a_sweep_range, clk, arst_n, state_q == ST_SWEEP, (j_q != '0) && (j_q <= len_q))
	`RDSM_ASSERT_IMP(a_res_from_finish, clk, arst_n, $rose(res.valid), $past(state_q == ST_FINISH))
	`RDSM_ASSERT_IMP(a_no_match_on_ovf, clk, arst_n, res.valid && res.overflow, !res.matched)

endmodule

>>> sim/tb_regex_dot_star_match.sv
// testbench of the dot-star matcher: directed table, random sessions, result scoreboard
module tb_regex_dot_star_match;
	import rdsm_pkg::*;

	// a result word as the block reports it
	typedef struct packed {
		logic matched;
		logic overflow;
	} verdict_t;

	localparam verdict_t HIT  = '{matched: 1'b1, overflow: 1'b0};
	localparam verdict_t MISS = '{matched: 1'b0, overflow: 1'b0};
	localparam verdict_t OVF  = '{matched: 1'b0, overflow: 1'b1};

	localparam sym_t ChA = 8'h61;
	localparam sym_t ChB = 8'h62;

	localparam int RandWords  = 300;
	localparam int TailStart  = 240;  // no idling on either side from here on
	localparam int HoldCycles = 300;

	// one row of the directed table: a word repeated reps times, with an
	// optional pinned result for end words whose outcome is obvious
	typedef struct {
		mode_t    mode;
		sym_t     sym;
		int       reps;
		bit       pinned;
		verdict_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	rdsm_cmd_if cmd_ch ();
	rdsm_res_if res_ch ();

	regex_dot_star_match dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// matcher predictor: own copy of pattern, length, row and flags
	// ---------------------------------------------------------------
	sym_t pat_mem [PatternMax];
	int   pat_len;
	row_t prefix_hits;   // bit j: text so far matches first j pattern bytes
	bit   text_open;     // a text byte or end word has been seen since reset of the row
	bit   pat_overflow;

	verdict_t verdicts_due [$];
	verdict_t head;
	int       errors;
	int       words_sent;

	// idling controls, set by the stimulus process
	bit gaps_on;
	bit res_stalls_on;
	bit hold_req;

	function automatic bit byte_fits(sym_t pc, sym_t c);
		return (pc == SymAny) || (pc == c);
	endfunction

	task automatic rewind_row();
		prefix_hits = row_t'(1);
		text_open   = 1'b0;
	endtask

	task automatic step_matcher(input mode_t m, input sym_t s, output bit has_verdict,
			output verdict_t v);
		row_t nxt;
		bit   more;
		has_verdict = 1'b0;
		v = MISS;
		case (m)
		MODE_CLEAR: begin
			pat_len      = 0;
			pat_overflow = 1'b0;
			rewind_row();
		end
		MODE_APPEND: begin
			// a full store drops the byte and flags it
			if (pat_len < PatternMax) begin
				pat_mem[pat_len] = s;
				pat_len++;
			end else begin
				pat_overflow = 1'b1;
			end
			rewind_row();
		end
		default: begin
			// first text word: widen the row so leading star groups match empty text
			if (!text_open) begin
				for (int j = 2; j <= pat_len; j++)
					if (pat_mem[j-1] == SymStar && prefix_hits[j-2])
						prefix_hits[j] = 1'b1;
				text_open = 1'b1;
			end
			if (m == MODE_TEXT) begin
				nxt = '0;
				for (int j = 1; j <= pat_len; j++) begin
					if (pat_mem[j-1] == SymStar) begin
						// star in front has nothing to repeat and stays 0
						if (j >= 2) begin
							more   = prefix_hits[j] && byte_fits(pat_mem[j-2], s);
							nxt[j] = nxt[j-2] || more;
						end
					end else begin
						nxt[j] = prefix_hits[j-1] && byte_fits(pat_mem[j-1], s);
					end
				end
				prefix_hits = nxt;
			end else begin
				has_verdict = 1'b1;
				v.matched   = !pat_overflow && prefix_hits[pat_len];
				v.overflow  = pat_overflow;
				rewind_row();
			end
		end
		endcase
	endtask

	// ---------------------------------------------------------------
	// command side
	// ---------------------------------------------------------------
	// offers one word, waits for the handshake, then updates the predictor
	task automatic send_word(input mode_t m, input sym_t s, input bit pinned = 1'b0,
			input verdict_t want = MISS);
		bit       has_v;
		verdict_t v;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		cmd_ch.valid  <= 1'b1;
		cmd_ch.mode   <= m;
		cmd_ch.symbol <= s;
		do @(posedge clk); while (!cmd_ch.ready);
		step_matcher(m, s, has_v, v);
		if (has_v)
			verdicts_due.push_back(pinned ? want : v);
		words_sent++;
	endtask

	// sender goes quiet until every outstanding result is back
	task automatic pause_until_drained();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (verdicts_due.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// text bytes lean on a small alphabet so matches actually happen
	function automatic sym_t text_byte();
		case ($urandom_range(0, 9))
		0, 1, 2, 3, 4: return ChA;
		5, 6, 7: return ChB;
		8: return SymStar;
		default: return sym_t'($urandom);
		endcase
	endfunction

	// one session: maybe a clear, a pattern, then a few texts each closed by an end word
	task automatic random_session();
		int   plen;
		int   ntexts;
		int   tlen;
		int   r;
		sym_t ps;
		if ($urandom_range(0, 3) != 0)
			send_word(MODE_CLEAR, sym_t'($urandom));
		// mostly short patterns, now and then a full store or up to three bytes past it
		r = $urandom_range(0, 19);
		if (r == 0)
			plen = 0;
		else if (r <= 15)
			plen = $urandom_range(1, 6);
		else if (r <= 17)
			plen = $urandom_range(7, 16);
		else if (r == 18)
			plen = PatternMax;
		else
			plen = $urandom_range(PatternMax + 1, PatternMax + 3);
		repeat (plen) begin
			case ($urandom_range(0, 9))
			0, 1, 2, 3: ps = ChA;
			4, 5: ps = ChB;
			6, 7: ps = SymAny;
			8: ps = SymStar;
			default: ps = sym_t'($urandom);
			endcase
			send_word(MODE_APPEND, ps);
		end
		ntexts = $urandom_range(1, 4);
		repeat (ntexts) begin
			tlen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
			repeat (tlen) begin
				// stray word now and then: a clear or append cuts the text short
				if ($urandom_range(0, 29) == 0)
					send_word(mode_t'($urandom_range(0, 3)), sym_t'($urandom));
				send_word(MODE_TEXT, text_byte());
			end
			send_word(MODE_END, sym_t'($urandom));
		end
	endtask

	// ---------------------------------------------------------------
	// result side: ready with random stall bursts and one long hold
	// ---------------------------------------------------------------
	initial begin
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				// long hold so the result register fills and the command side stalls
				res_ch.ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_req = 1'b0;
			end else if (res_stalls_on && $urandom_range(0, 7) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// scoreboard: each result word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_ch.valid && res_ch.ready) begin
			if (verdicts_due.size() == 0) begin
				$display("%0t: unexpected result word, matched %b overflow %b", $time,
					res_ch.matched, res_ch.overflow);
				errors++;
			end else begin
				head = verdicts_due.pop_front();
				if (res_ch.matched !== head.matched) begin
					$display("%0t: matched expected %b actual %b", $time, head.matched,
						res_ch.matched);
					errors++;
				end
				if (res_ch.overflow !== head.overflow) begin
					$display("%0t: overflow expected %b actual %b", $time, head.overflow,
						res_ch.overflow);
					errors++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	plan_row_t plan [$];

	initial begin
		arst_n        = 1'b0;
		cmd_ch.valid  = 1'b0;
		cmd_ch.mode   = MODE_CLEAR;
		cmd_ch.symbol = '0;
		errors        = 0;
		words_sent    = 0;
		gaps_on       = 1'b1;
		res_stalls_on = 1'b1;
		hold_req      = 1'b0;
		foreach (pat_mem[i])
			pat_mem[i] = '0;
		pat_len      = 0;
		pat_overflow = 1'b0;
		rewind_row();

		plan = '{
			// empty pattern: matches the empty text only
			'{MODE_END,    8'h00,      1, 1'b1, HIT},
			'{MODE_TEXT,   8'hFF,      1, 1'b0, MISS},
			'{MODE_END,    8'hFF,      1, 1'b1, MISS},
			// star with nothing in front never matches
			'{MODE_APPEND, SymStar,    1, 1'b0, MISS},
			'{MODE_END,    8'h00,      1, 1'b1, MISS},
			'{MODE_TEXT,   ChA,        1, 1'b0, MISS},
			'{MODE_END,    8'h00,      1, 1'b0, MISS},
			// leading star group against the empty text
			'{MODE_CLEAR,  8'h00,      1, 1'b0, MISS},
			'{MODE_APPEND, 8'hFF,      1, 1'b0, MISS},
			'{MODE_APPEND, SymStar,    1, 1'b0, MISS},
			'{MODE_END,    8'h00,      1, 1'b1, HIT},
			'{MODE_APPEND, SymAny,     1, 1'b0, MISS},
			'{MODE_TEXT,   8'hFF,      2, 1'b0, MISS},
			'{MODE_TEXT,   8'h00,      1, 1'b0, MISS},
			'{MODE_END,    8'h00,      1, 1'b0, MISS},
			// append in the middle of a text drops the text
			'{MODE_TEXT,   8'h71,      1, 1'b0, MISS},
			'{MODE_APPEND, SymStar,    1, 1'b0, MISS},
			// star right after a star repeats a literal star byte
			'{MODE_APPEND, SymStar,    1, 1'b0, MISS},
			'{MODE_TEXT,   SymStar,    3, 1'b0, MISS},
			'{MODE_END,    8'h00,      1, 1'b0, MISS},
			// full store, then one byte too many
			'{MODE_CLEAR,  8'hFF,      1, 1'b0, MISS},
			'{MODE_APPEND, SymAny,     PatternMax, 1'b0, MISS},
			'{MODE_TEXT,   8'h80,      PatternMax, 1'b0, MISS},
			'{MODE_END,    8'h00,      1, 1'b0, MISS},
			'{MODE_APPEND, ChA,        1, 1'b0, MISS},
			'{MODE_END,    8'h00,      1, 1'b1, OVF},
			'{MODE_TEXT,   8'h7F,      1, 1'b0, MISS},
			'{MODE_END,    8'h00,      1, 1'b1, OVF},
			// clear drops the overflow flag
			'{MODE_CLEAR,  8'h00,      1, 1'b0, MISS},
			'{MODE_END,    8'h00,      1, 1'b1, HIT}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			repeat (plan[i].reps)
				send_word(plan[i].mode, plan[i].sym, plan[i].pinned, plan[i].want);
		pause_until_drained();

		words_sent = 0;
		for (int sess = 0; words_sent < RandWords; sess++) begin
			gaps_on       = (words_sent < TailStart) && ($urandom_range(0, 3) != 0);
			res_stalls_on = (words_sent < TailStart) && ($urandom_range(0, 3) != 0);
			if (sess == 8) begin
				// receiver holds off while several end words queue up behind it
				gaps_on  = 1'b0;
				hold_req = 1'b1;
				send_word(MODE_CLEAR, 8'h00);
				send_word(MODE_APPEND, ChA);
				send_word(MODE_APPEND, SymStar);
				repeat (4) begin
					send_word(MODE_TEXT, text_byte());
					send_word(MODE_END, 8'h00);
				end
			end
			if (sess == 16)
				pause_until_drained();
			random_session();
		end

		pause_until_drained();
		repeat (3 * PatternMax) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

endmodule
